// ===== rtl/checked_integer_arithmetic_top_macros.svh =====
// assertion macros for the checked integer arithmetic block
`ifndef CHECKED_INTEGER_ARITHMETIC_TOP_MACROS_SVH
`define CHECKED_INTEGER_ARITHMETIC_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CIA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CIA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cia_pkg.sv =====
// ----------------------------------------------------------------------------
// cia_pkg
// shared opcode type for the checked integer arithmetic block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cia_pkg;

    typedef enum logic [2:0] {
        OP_SADD = 3'd0,
        OP_SSUB = 3'd1,
        OP_SMUL = 3'd2,
        OP_SDIV = 3'd3,
        OP_UADD = 3'd4,
        OP_USUB = 3'd5,
        OP_UMUL = 3'd6,
        OP_UDIV = 3'd7
    } opcode_t;

endpackage

`default_nettype wire

// ===== rtl/cia_mul.sv =====
// ----------------------------------------------------------------------------
// cia_mul
// two-stage unsigned multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_mul #(
    parameter int WIDTH = 64
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [WIDTH-1:0]             a,
    input  wire logic [WIDTH-1:0]             b,
    output logic      [4*((WIDTH+1)/2)-1:0]   prod
);

    localparam int H  = (WIDTH + 1) / 2;
    localparam int PW = 4 * H;

    logic [2*H-1:0] a_ext;
    logic [2*H-1:0] b_ext;
    logic [2*H-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [PW-1:0]  prod_reg;
    logic [PW-1:0]  prod_next;

    assign a_ext = (2*H)'(a);
    assign b_ext = (2*H)'(b);

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a_ext[H-1:0]   * b_ext[H-1:0];
            lh_reg <= a_ext[H-1:0]   * b_ext[2*H-1:H];
            hl_reg <= a_ext[2*H-1:H] * b_ext[H-1:0];
            hh_reg <= a_ext[2*H-1:H] * b_ext[2*H-1:H];
        end
    end

    // partial product sum
    assign prod_next = PW'(ll_reg)
                     + ((PW'(lh_reg) + PW'(hl_reg)) << H)
                     + (PW'(hh_reg) << (2*H));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/cia_div.sv =====
// ----------------------------------------------------------------------------
// cia_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_div #(
    parameter int WIDTH = 64
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic      [WIDTH-1:0] quotient
);

    logic [WIDTH-1:0] rem_reg [0:WIDTH-1];
    logic [WIDTH-1:0] quo_reg [0:WIDTH-1];
    logic [WIDTH-1:0] dvs_reg [0:WIDTH-1];

    for (genvar k = 0; k < WIDTH; k++)
    begin : g_stage
        logic [WIDTH-1:0] rem_prev, quo_prev, dvs_prev;
        logic [WIDTH:0]   trial;
        logic [WIDTH:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_prev = '0;
            assign quo_prev = dividend;
            assign dvs_prev = divisor;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign quo_prev = quo_reg[k-1];
            assign dvs_prev = dvs_reg[k-1];
        end

        // shift in next dividend bit and try the subtract
        assign trial = {rem_prev, quo_prev[WIDTH-1]};
        assign ge    = trial >= {1'b0, dvs_prev};
        assign diff  = trial - {1'b0, dvs_prev};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
                quo_reg[k] <= {quo_prev[WIDTH-2:0], ge};
                dvs_reg[k] <= dvs_prev;
            end
        end
    end

    assign quotient = quo_reg[WIDTH-1];

endmodule

`default_nettype wire

// ===== rtl/checked_integer_arithmetic_top.sv =====
// ----------------------------------------------------------------------------
// checked_integer_arithmetic_top
// overflow-checked signed and unsigned add, subtract, multiply and divide
// ----------------------------------------------------------------------------
// Accepts one request per cycle while in_stall is low and presents each result
// in the order its request was accepted. The pipeline depth is set by the
// divider, which resolves one quotient bit per pipeline stage; all other
// operations ride along in a matching delay line. A stall on the output
// freezes the whole pipeline and holds in_stall high until the waiting result
// is taken. Operands are taken modulo 2^WIDTH, and on any overflow or invalid
// operation value is zero and status is one.
`timescale 1ns / 1ps
`default_nettype none

module checked_integer_arithmetic_top
    import cia_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    input  wire logic [63:0] limit,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      value,
    output logic             status
);

    localparam int H  = (WIDTH + 1) / 2;
    localparam int PW = 4 * H;
    localparam logic [63:0]      MASK64 = 64'((65'd1 << WIDTH) - 65'd1);
    localparam logic [WIDTH-1:0] MASK_W = {WIDTH{1'b1}};
    localparam logic [WIDTH-1:0] MIN_W  = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MAX_W  = {1'b0, {(WIDTH-1){1'b1}}};

    typedef struct packed {
        logic             valid;
        opcode_t          op;
        logic [WIDTH-1:0] res;
        logic             err;
        logic             neg;
        logic [WIDTH-1:0] lim;
    } line_t;

    logic             en;
    opcode_t          op;
    logic [WIDTH-1:0] a, b, lim_w, ma, mb, sum, dif;
    logic [WIDTH:0]   usum;
    logic             sa, sb;
    line_t            head;
    logic [WIDTH-1:0] mula_next, mulb_next, dvd_next, dvs_next;
    logic [WIDTH-1:0] mula_reg, mulb_reg, dvd_reg, dvs_reg;
    line_t            line_reg [0:WIDTH];
    line_t            mul_fix;
    line_t            fin;
    logic [PW-1:0]    prod;
    logic [WIDTH-1:0] quo;
    logic [WIDTH-1:0] bound;
    logic             out_valid_reg;
    logic [63:0]      value_reg;
    logic             status_reg;

    // pipeline advances unless a finished result is held
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // operand decode
    assign op    = opcode_t'(opcode);
    assign a     = operand_a[WIDTH-1:0];
    assign b     = operand_b[WIDTH-1:0];
    assign sa    = a[WIDTH-1];
    assign sb    = b[WIDTH-1];
    assign lim_w = (limit > MASK64) ? MASK_W : limit[WIDTH-1:0];
    assign ma    = sa ? (WIDTH'(0) - a) : a;
    assign mb    = sb ? (WIDTH'(0) - b) : b;
    assign sum   = a + b;
    assign dif   = a - b;
    assign usum  = {1'b0, a} + {1'b0, b};

    // add and subtract results, early error checks
    always_comb
    begin
        head       = '0;
        head.valid = in_valid && !in_stall;
        head.op    = op;
        head.lim   = lim_w;
        head.neg   = sa ^ sb;
        mula_next  = a;
        mulb_next  = b;
        dvd_next   = a;
        dvs_next   = b;
        case (op)
            OP_SADD:
            begin
                head.res = sum;
                head.err = (sa == sb) && (sum[WIDTH-1] != sa);
            end
            OP_SSUB:
            begin
                head.res = dif;
                head.err = (sa != sb) && (dif[WIDTH-1] != sa);
            end
            OP_SMUL:
            begin
                mula_next = ma;
                mulb_next = mb;
            end
            OP_SDIV:
            begin
                head.err = (b == '0) || ((a == MIN_W) && (b == MASK_W));
                dvd_next = ma;
                dvs_next = mb;
            end
            OP_UADD:
            begin
                head.res = sum;
                head.err = usum > {1'b0, lim_w};
            end
            OP_USUB:
            begin
                head.res = dif;
                head.err = a < b;
            end
            OP_UMUL:
            begin
                head.err = 1'b0;
            end
            OP_UDIV:
            begin
                head.err = (b == '0);
            end
            default:
            begin
                head.err = 1'b1;
            end
        endcase
    end

    // first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg[0].valid <= 1'b0;
        end
        else if (en)
        begin
            line_reg[0] <= head;
            mula_reg    <= mula_next;
            mulb_reg    <= mulb_next;
            dvd_reg     <= dvd_next;
            dvs_reg     <= dvs_next;
        end
    end

    cia_mul #(
        .WIDTH (WIDTH)
    ) u_mul (
        .clk  (clk),
        .en   (en),
        .a    (mula_reg),
        .b    (mulb_reg),
        .prod (prod)
    );

    cia_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .clk      (clk),
        .en       (en),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .quotient (quo)
    );

    // multiply range check, merged when the product lines up
    assign bound = line_reg[2].neg ? MIN_W : MAX_W;

    always_comb
    begin
        mul_fix = line_reg[2];
        if (line_reg[2].op == OP_UMUL)
        begin
            mul_fix.err = prod > PW'(line_reg[2].lim);
            mul_fix.res = prod[WIDTH-1:0];
        end
        else if (line_reg[2].op == OP_SMUL)
        begin
            mul_fix.err = prod > PW'(bound);
            mul_fix.res = line_reg[2].neg ? (WIDTH'(0) - prod[WIDTH-1:0])
                                          : prod[WIDTH-1:0];
        end
    end

    // delay line matching the divider depth
    for (genvar k = 1; k <= WIDTH; k++)
    begin : g_line
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                line_reg[k].valid <= 1'b0;
            end
            else if (en)
            begin
                line_reg[k] <= (k == 3) ? mul_fix : line_reg[k-1];
            end
        end
    end

    // quotient sign and final result
    always_comb
    begin
        fin = line_reg[WIDTH];
        if (fin.op == OP_SDIV)
        begin
            fin.res = fin.neg ? (WIDTH'(0) - quo) : quo;
        end
        else if (fin.op == OP_UDIV)
        begin
            fin.res = quo;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin.valid;
            value_reg     <= fin.err ? 64'd0 : 64'(fin.res);
            status_reg    <= fin.err;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ===== rtl/cia_chk.sv =====
// ----------------------------------------------------------------------------
// cia_chk
// port-level checks for the checked integer arithmetic block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "checked_integer_arithmetic_top_macros.svh"

module cia_chk (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_stall,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [63:0] value,
    input  wire logic        status
);

    // held result keeps its payload
    `CIA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(value) && $stable(status), "stalled result changed")

    // input backpressure only comes from a held result
    `CIA_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a held result")

    // a free output side never stalls the input
    `CIA_ASSERT_IMP(a_stall_release, clk, rst_n, !out_stall, !in_stall, "input stalled while output is free")

    // errors always come with a zero value
    `CIA_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && status, value == 64'd0, "error result with nonzero value")

endmodule

bind checked_integer_arithmetic_top cia_chk u_chk (.*);

`default_nettype wire

// ===== tb/tb_checked_integer_arithmetic_top.sv =====
// ----------------------------------------------------------------------------
// tb_checked_integer_arithmetic_top
// self-checking bench for the overflow-checked arithmetic unit
// ----------------------------------------------------------------------------
// A directed table covers every opcode, the operand extremes and each error
// case (signed overflow, MIN / -1, divide by zero, unsigned borrow, limit
// exceeded). Random requests follow under three idling patterns and a long
// output hold-off. Results are checked against known values or an in-bench predictor.
`timescale 1ns / 1ps

module tb_checked_integer_arithmetic_top;
    import cia_pkg::*;

    localparam int          LAT       = 66;
    localparam int          WATCHDOG  = 20000;
    localparam int          N_RANDOM  = 726;
    localparam logic [63:0] SMIN      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SMAX      = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] ALL1      = '1;

    typedef struct {
        opcode_t     op;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] lim;
        bit          known;
        logic [63:0] val;
        logic        st;
    } row_t;

    typedef struct {
        logic [63:0] val;
        logic        st;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [63:0] limit;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] value;
    logic        status;

    outcome_t    pending_results[$];
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          quiet_cycles;
    row_t        directed[$];

    checked_integer_arithmetic_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .limit     (limit),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // magnitude of a two's complement word
    function automatic logic [63:0] abs64(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // checked arithmetic predictor
    function automatic outcome_t checked_result(opcode_t op, logic [63:0] a,
                                                logic [63:0] b, logic [63:0] lim);
        outcome_t    o;
        logic [63:0] r;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [127:0] p;
        logic        neg;
        logic        bad;
        r   = '0;
        bad = 1'b0;
        ma  = abs64(a);
        mb  = abs64(b);
        neg = a[63] ^ b[63];
        case (op)
            OP_SADD:
            begin
                r   = a + b;
                bad = (a[63] == b[63]) && (r[63] != a[63]);
            end
            OP_SSUB:
            begin
                r   = a - b;
                bad = (a[63] != b[63]) && (r[63] != a[63]);
            end
            OP_SMUL:
            begin
                p = ma * mb;
                if (ma == 0 || mb == 0)
                    r = '0;
                else if (p <= (neg ? {64'd0, SMIN} : {64'd0, SMAX}))
                    r = neg ? -p[63:0] : p[63:0];
                else
                    bad = 1'b1;
            end
            OP_SDIV:
            begin
                if (b == 0 || (a == SMIN && b == ALL1))
                    bad = 1'b1;
                else
                begin
                    q = ma / mb;
                    r = neg ? -q : q;
                end
            end
            OP_UADD:
            begin
                if (a <= lim && lim - a >= b)
                    r = a + b;
                else
                    bad = 1'b1;
            end
            OP_USUB:
            begin
                if (a >= b)
                    r = a - b;
                else
                    bad = 1'b1;
            end
            OP_UMUL:
            begin
                p = a * b;
                if (a == 0 || p <= {64'd0, lim})
                    r = p[63:0];
                else
                    bad = 1'b1;
            end
            default:
            begin
                if (b != 0)
                    r = a / b;
                else
                    bad = 1'b1;
            end
        endcase
        o.val = bad ? '0 : r;
        o.st  = bad;
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // operand biased toward edges and small magnitudes
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return SMIN;
            1:       return SMAX;
            2:       return ALL1;
            3:       return 64'($urandom_range(0, 5));
            4:       return -64'($urandom_range(1, 5));
            5:       return 64'($urandom);
            6:       return -64'($urandom);
            7:       return rand64() >> $urandom_range(1, 63);
            default: return rand64();
        endcase
    endfunction

    // send one request, waiting for acceptance
    task automatic send_request(opcode_t op, logic [63:0] a, logic [63:0] b,
                                logic [63:0] lim, bit known,
                                logic [63:0] val, logic st);
        outcome_t o;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        operand_a <= a;
        operand_b <= b;
        limit     <= lim;
        o = checked_result(op, a, b, lim);
        if (known)
        begin
            o.val = val;
            o.st  = st;
        end
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(o);
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // result check
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual value=%h status=%b",
                         $time, value, status);
            end
            else
            begin
                e = pending_results.pop_front();
                if (value !== e.val)
                begin
                    errors++;
                    $display("%0t: value mismatch expected %h actual %h",
                             $time, e.val, value);
                end
                if (status !== e.st)
                begin
                    errors++;
                    $display("%0t: status mismatch expected %b actual %b",
                             $time, e.st, status);
                end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // add one directed row
    task automatic add_row(opcode_t op, logic [63:0] a, logic [63:0] b,
                           logic [63:0] lim, bit known, logic [63:0] val, logic st);
        row_t r;
        r.op = op; r.a = a; r.b = b; r.lim = lim;
        r.known = known; r.val = val; r.st = st;
        directed.push_back(r);
    endtask

    // stimulus
    initial
    begin
        int k;
        int phase;
        errors        = 0;
        quiet_cycles  = 0;
        hold_off      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        opcode        = OP_SADD;
        operand_a     = '0;
        operand_b     = '0;
        limit         = '0;

        add_row(OP_SADD, SMAX, 64'd1, '0, 1, '0, 1'b1);
        add_row(OP_SADD, SMIN, ALL1, '0, 1, '0, 1'b1);
        add_row(OP_SADD, SMAX, SMIN, '0, 1, ALL1, 1'b0);
        add_row(OP_SSUB, SMIN, 64'd1, '0, 1, '0, 1'b1);
        add_row(OP_SSUB, '0, SMIN, '0, 1, '0, 1'b1);
        add_row(OP_SSUB, ALL1, SMIN, '0, 1, SMAX, 1'b0);
        add_row(OP_SMUL, SMIN, '0, '0, 1, '0, 1'b0);
        add_row(OP_SMUL, SMIN, ALL1, '0, 1, '0, 1'b1);
        add_row(OP_SMUL, SMIN, 64'd1, '0, 1, SMIN, 1'b0);
        add_row(OP_SMUL, 64'h4000_0000_0000_0000, -64'd2, '0, 1, SMIN, 1'b0);
        add_row(OP_SMUL, 64'h4000_0000_0000_0000, 64'd2, '0, 1, '0, 1'b1);
        add_row(OP_SDIV, SMIN, ALL1, '0, 1, '0, 1'b1);
        add_row(OP_SDIV, SMAX, '0, '0, 1, '0, 1'b1);
        add_row(OP_SDIV, -64'd7, 64'd2, '0, 1, -64'd3, 1'b0);
        add_row(OP_SDIV, SMIN, 64'd1, '0, 1, SMIN, 1'b0);
        add_row(OP_UADD, 64'd5, '0, 64'd4, 1, '0, 1'b1);
        add_row(OP_UADD, ALL1, '0, ALL1, 1, ALL1, 1'b0);
        add_row(OP_UADD, ALL1, 64'd1, ALL1, 1, '0, 1'b1);
        add_row(OP_USUB, '0, 64'd1, '0, 1, '0, 1'b1);
        add_row(OP_USUB, ALL1, ALL1, '0, 1, '0, 1'b0);
        add_row(OP_UMUL, '0, ALL1, '0, 1, '0, 1'b0);
        add_row(OP_UMUL, ALL1, '0, '0, 1, '0, 1'b0);
        add_row(OP_UMUL, 64'h1_0000_0000, 64'h1_0000_0000, ALL1, 1, '0, 1'b1);
        add_row(OP_UMUL, 64'd3, 64'd5, 64'd15, 1, 64'd15, 1'b0);
        add_row(OP_UDIV, ALL1, '0, '0, 1, '0, 1'b1);
        add_row(OP_UDIV, ALL1, 64'd2, '0, 0, '0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed[i])
            send_request(directed[i].op, directed[i].a, directed[i].b, directed[i].lim,
                         directed[i].known, directed[i].val, directed[i].st);

        // long output hold-off while the sender keeps offering requests
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            for (k = 0; k < 100; k++)
                send_request(opcode_t'($urandom_range(0, 7)), pick_operand(),
                             pick_operand(), pick_operand(), 0, '0, 1'b0);
        join

        // random requests under three idling patterns
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 31 : 0;
            for (k = 0; k < N_RANDOM / 3; k++)
                send_request(opcode_t'($urandom_range(0, 7)), pick_operand(),
                             pick_operand(), pick_operand(), 0, '0, 1'b0);
        end
        in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LAT) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cia_pkg.sv
rtl/cia_mul.sv
rtl/cia_div.sv
rtl/checked_integer_arithmetic_top.sv
rtl/cia_chk.sv
tb/tb_checked_integer_arithmetic_top.sv
